/* hdl/drl_pkg.sv */
// shared command and status types for the direct line rasterizer
package drl_pkg;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture a new line item
      logic div_step;   // one restoring division step of |dy| / dx
      logic div_fix;    // turn the unsigned quotient into a floor step
      logic advance;    // move to the next pixel
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;       // current pixel is the right endpoint
   } status_type;

endpackage

/* hdl/direct_line_rasterizer_top.sv */
// top level of the direct slope-intercept line rasterizer
// Takes one line item with two signed endpoints and streams one pixel per x from the left
// endpoint to the right one, y rounded half away from zero from the exact rational slope,
// the last pixel marked with rsp_tlast; a vertical line (equal x) gives the start point alone.
// Per line: the item is accepted, the serial restoring divider splits dy/dx into an integer
// step and a remainder step, the sign of that step is fixed, then dx+1 pixels go out at one
// per cycle while rsp_tready is high. A new item is taken only after the last pixel has gone.
module direct_line_rasterizer_top #(
   parameter  int COORD_BITS = 6,
   localparam int REQ_W      = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // x_start, y_start, x_end, y_end, zero pad
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // pixel_x, pixel_y, zero pad
   output logic [RSP_W-1:0]     rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int CB    = COORD_BITS;

   drl_pkg::cmd_type    cmd;
   drl_pkg::status_type status;

   logic signed [CB-1:0] x_start, y_start, x_end, y_end;
   logic signed [CB-1:0] pixel_x, pixel_y;

   // unpack the line item
   assign x_start = req_tdata[CB-1:0];
   assign y_start = req_tdata[2*CB-1:CB];
   assign x_end   = req_tdata[3*CB-1:2*CB];
   assign y_end   = req_tdata[4*CB-1:3*CB];

   drl_controller #(
      .COORD_BITS(COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   drl_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .x_start (x_start),
      .y_start (y_start),
      .x_end   (x_end),
      .y_end   (y_end),
      .pixel_x (pixel_x),
      .pixel_y (pixel_y),
      .status  (status)
   );

   // pack the pixel item, zero padded to whole bytes
   assign rsp_tdata = {{(RSP_W - 2*CB){1'b0}}, pixel_y, pixel_x};
   assign rsp_tlast = status.last;

`ifndef SYNTHESIS
   // taking the last pixel returns the block to accepting lines
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block not ready after last pixel");

   // no pixel is shown in the cycle after a line is taken (divider runs first)
   a_setup_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("pixel shown during slope setup");

   // input and output sides never overlap
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("accepting a line while pixels are pending");
`endif

endmodule

/* hdl/drl_datapath.sv */
// datapath: endpoint setup, serial slope divider and incremental y tracker
module drl_datapath #(
   parameter int COORD_BITS = 6
) (
   input  logic                          clock,
   input  drl_pkg::cmd_type              cmd,
   input  logic signed [COORD_BITS-1:0]  x_start,
   input  logic signed [COORD_BITS-1:0]  y_start,
   input  logic signed [COORD_BITS-1:0]  x_end,
   input  logic signed [COORD_BITS-1:0]  y_end,
   output logic signed [COORD_BITS-1:0]  pixel_x,
   output logic signed [COORD_BITS-1:0]  pixel_y,
   output drl_pkg::status_type           status
);

   localparam int CB = COORD_BITS;

   // line registers
   logic [CB-1:0] x_ff, x_in;
   logic [CB-1:0] x_last_ff, x_last_in;
   logic [CB-1:0] q_ff, q_in;            // floor of current y, signed
   logic [CB-1:0] r_ff, r_in;            // remainder of current y, 0..dx-1
   logic [CB-1:0] dx_ff, dx_in;
   logic          dy_neg_ff, dy_neg_in;
   logic [CB:0]   dq_ff, dq_in;          // floor(dy/dx), signed
   logic [CB-1:0] dr_ff, dr_in;          // dy - dq*dx
   logic [CB-1:0] div_quo_ff, div_quo_in;
   logic [CB-1:0] div_rem_ff, div_rem_in;

   // endpoint ordering
   logic          swap;
   logic [CB-1:0] xa, ya, xb, yb;
   logic [CB:0]   dx_wide, dy_wide, dy_mag;

   // divider step
   logic [CB:0]   rem_shift, rem_sub;
   logic          div_ge;

   // pixel step
   logic [CB:0]   r_sum, r_sub;
   logic          step_ge;
   logic [CB+1:0] q_sum;

   // rounding
   logic [CB:0]   twice_r;
   logic          round_up;

   always_comb begin
      swap = x_start > x_end;
      xa   = swap ? x_end   : x_start;
      ya   = swap ? y_end   : y_start;
      xb   = swap ? x_start : x_end;
      yb   = swap ? y_start : y_end;
      dx_wide = {xb[CB-1], xb} - {xa[CB-1], xa};
      dy_wide = {yb[CB-1], yb} - {ya[CB-1], ya};
      dy_mag  = dy_wide[CB] ? (~dy_wide + {{CB{1'b0}}, 1'b1}) : dy_wide;

      rem_shift = {div_rem_ff, div_quo_ff[CB-1]};
      rem_sub   = rem_shift - {1'b0, dx_ff};
      div_ge    = rem_shift >= {1'b0, dx_ff};

      r_sum   = {1'b0, r_ff} + {1'b0, dr_ff};
      r_sub   = r_sum - {1'b0, dx_ff};
      step_ge = r_sum >= {1'b0, dx_ff};
      q_sum   = {{2{q_ff[CB-1]}}, q_ff} + {dq_ff[CB], dq_ff}
              + {{(CB+1){1'b0}}, step_ge};

      // half away from zero: a tie rounds up only when y is non-negative
      twice_r  = {r_ff, 1'b0};
      round_up = (dx_ff != '0) &&
                 (q_ff[CB-1] ? (twice_r > {1'b0, dx_ff}) : (twice_r >= {1'b0, dx_ff}));
   end

   always_comb begin
      x_in       = x_ff;
      x_last_in  = x_last_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      dx_in      = dx_ff;
      dy_neg_in  = dy_neg_ff;
      dq_in      = dq_ff;
      dr_in      = dr_ff;
      div_quo_in = div_quo_ff;
      div_rem_in = div_rem_ff;
      if (cmd.load) begin
         x_in       = xa;
         x_last_in  = xb;
         q_in       = ya;
         r_in       = '0;
         dx_in      = dx_wide[CB-1:0];
         dy_neg_in  = dy_wide[CB];
         div_quo_in = dy_mag[CB-1:0];
         div_rem_in = '0;
      end else if (cmd.div_step) begin
         div_rem_in = div_ge ? rem_sub[CB-1:0] : rem_shift[CB-1:0];
         div_quo_in = {div_quo_ff[CB-2:0], div_ge};
      end else if (cmd.div_fix) begin
         if (!dy_neg_ff) begin
            dq_in = {1'b0, div_quo_ff};
            dr_in = div_rem_ff;
         end else if (div_rem_ff == '0) begin
            dq_in = ~{1'b0, div_quo_ff} + {{CB{1'b0}}, 1'b1};
            dr_in = '0;
         end else begin
            dq_in = ~{1'b0, div_quo_ff};
            dr_in = dx_ff - div_rem_ff;
         end
      end else if (cmd.advance) begin
         x_in = x_ff + {{(CB-1){1'b0}}, 1'b1};
         r_in = step_ge ? r_sub[CB-1:0] : r_sum[CB-1:0];
         q_in = q_sum[CB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      x_last_ff  <= x_last_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      dx_ff      <= dx_in;
      dy_neg_ff  <= dy_neg_in;
      dq_ff      <= dq_in;
      dr_ff      <= dr_in;
      div_quo_ff <= div_quo_in;
      div_rem_ff <= div_rem_in;
   end

   assign pixel_x     = x_ff;
   assign pixel_y     = q_ff + {{(CB-1){1'b0}}, round_up};
   assign status.last = x_ff == x_last_ff;

endmodule

/* hdl/drl_controller.sv */
// controller: sequences setup, slope division and pixel output
module drl_controller #(
   parameter int COORD_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  drl_pkg::status_type  status,
   output drl_pkg::cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam int CNT_W = $clog2(COORD_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_BITS - 1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready   = state_ff == ST_IDLE;
   assign rsp_tvalid   = state_ff == ST_EMIT;
   assign cmd.load     = req_tvalid && req_tready;
   assign cmd.div_step = state_ff == ST_DIV;
   assign cmd.div_fix  = state_ff == ST_FIX;
   assign cmd.advance  = rsp_tvalid && rsp_tready;

endmodule

/* sim/direct_line_rasterizer_top_tb.sv */
// self-checking stream testbench for the direct slope-intercept line rasterizer
`timescale 1ns / 1ps

module direct_line_rasterizer_top_tb;

   localparam int COORD_BITS   = 6;
   localparam int REQ_W        = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int LINES_PER_PH = 43;
   localparam int LONG_HOLD    = 300;
   // longest quiet stretch is the long hold plus one line's setup, so this is generous
   localparam int WATCHDOG_MAX = 2000;
   // waited out after the last pixel, before the verdict is printed
   localparam int TAIL_CYCLES  = COORD_BITS + 4;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   // one pixel as it leaves the rasterizer
   typedef struct {
      coord_t px;
      coord_t py;
      logic   last;
   } pixel_t;

   // one line item; pinned rows carry their single pixel typed in
   typedef struct {
      coord_t xs;
      coord_t ys;
      coord_t xe;
      coord_t ye;
      bit     pinned;
      coord_t pin_x;
      coord_t pin_y;
   } line_row_t;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // x_start, y_start, x_end, y_end, zero pad
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // pixel_x, pixel_y, zero pad
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   pixel_t pending_pixels[$];
   int     error_count = 0;
   int     quiet_cycles = 0;

   // idle rates in percent, set by the stimulus process
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;

   // long receiver hold: the stimulus side toggles the request, the receiver acks it
   bit     hold_request = 1'b0;
   bit     hold_ack = 1'b0;
   int     hold_left = 0;

   direct_line_rasterizer_top #(
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // directed lines: extremes, both draw directions, flat, steep, rounding ties
   line_row_t directed_rows[] = '{
      // vertical lines give only the start point, typed in
      '{  0,   0,   0,   0, 1,   0,   0},
      '{-32, -32, -32,  31, 1, -32, -32},
      '{ 31,  31,  31, -32, 1,  31,  31},
      '{ -1,  31,  -1, -32, 1,  -1,  31},
      // full-width diagonals in both directions, 64 pixels each
      '{-32, -32,  31,  31, 0,   0,   0},
      '{ 31,  31, -32, -32, 0,   0,   0},
      '{-32,  31,  31, -32, 0,   0,   0},
      '{ 31, -32, -32,  31, 0,   0,   0},
      // flat line across the whole range
      '{-32,   0,  31,   0, 0,   0,   0},
      // steep lines leave gaps in y
      '{  0, -32,   1,  31, 0,   0,   0},
      '{  1,  31,   0, -32, 0,   0,   0},
      '{-32,   5, -31,  -7, 0,   0,   0},
      '{ 31, -32,  30,  31, 0,   0,   0},
      // half-way ties round away from zero, plus a short flat line and a one-step diagonal
      '{  0,   0,   2,   1, 0,   0,   0},
      '{  0,   0,   2,  -1, 0,   0,   0},
      '{  0,   0,   4,   1, 0,   0,   0},
      '{  0,   0,   4,  -3, 0,   0,   0},
      '{ -5,  -5,   5,   6, 0,   0,   0},
      '{  5,   0,  -5,   1, 0,   0,   0},
      '{ 10, -20,  11, -20, 0,   0,   0},
      '{ -1,  -1,   0,   0, 0,   0,   0}
   };

   // rounded quotient, half away from zero; den is always positive
   function automatic int round_quotient(input int num, input int den);
      if (num >= 0)
         return (2 * num + den) / (2 * den);
      return -((2 * (-num) + den) / (2 * den));
   endfunction

   // expand one line item into the pixels it must produce
   function automatic void rasterize_line(input line_row_t row);
      int     xa;
      int     ya;
      int     xb;
      int     yb;
      int     dx;
      int     dy;
      int     swap;
      pixel_t pix;
      xa = row.xs;
      ya = row.ys;
      xb = row.xe;
      yb = row.ye;
      // always draw left to right
      if (xa > xb) begin
         swap = xa; xa = xb; xb = swap;
         swap = ya; ya = yb; yb = swap;
      end
      if (xa == xb) begin
         pix.px = coord_t'(xa);
         pix.py = coord_t'(ya);
         pix.last = 1'b1;
         pending_pixels.push_back(pix);
         return;
      end
      dx = xb - xa;
      dy = yb - ya;
      for (int t = 0; t <= dx; t++) begin
         pix.px = coord_t'(xa + t);
         pix.py = coord_t'(round_quotient(ya * dx + dy * t, dx));
         pix.last = (t == dx);
         pending_pixels.push_back(pix);
      end
   endfunction

   // random line, with a share of vertical and short lines
   function automatic line_row_t random_line();
      line_row_t row;
      int        mode;
      int        xe_int;
      row.xs = coord_t'($urandom);
      row.ys = coord_t'($urandom);
      row.xe = coord_t'($urandom);
      row.ye = coord_t'($urandom);
      row.pinned = 1'b0;
      row.pin_x = '0;
      row.pin_y = '0;
      mode = $urandom_range(9);
      if (mode == 0) begin
         row.xe = row.xs;
      end else if (mode <= 2) begin
         xe_int = int'(row.xs) + $urandom_range(1, 4);
         if (xe_int > 31)
            xe_int = int'(row.xs) - $urandom_range(1, 4);
         row.xe = coord_t'(xe_int);
      end
      return row;
   endfunction

   // offer one line item, with a random gap first, and record its pixels on acceptance
   task automatic send_line(input line_row_t row);
      pixel_t pix;
      int     gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= REQ_W'({row.ye, row.xe, row.ys, row.xs});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (row.pinned) begin
         pix.px = row.pin_x;
         pix.py = row.pin_y;
         pix.last = 1'b1;
         pending_pixels.push_back(pix);
      end else begin
         rasterize_line(row);
      end
   endtask

   // drop valid and wait until every expected pixel has come out
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   // receiver: random back-pressure, or a long hold when one is requested
   initial rsp_tready = 1'b0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request != hold_ack) begin
         hold_ack <= hold_request;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // pixel checker: every accepted pixel against the oldest expectation
   always @(posedge clock) begin : check_pixels
      pixel_t want;
      coord_t got_x;
      coord_t got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[COORD_BITS-1:0];
         got_y = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d last=%0b", got_x, got_y, rsp_tlast);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (got_x !== want.px) begin
               $error("pixel_x expected %0d got %0d", want.px, got_x);
               error_count++;
            end
            if (got_y !== want.py) begin
               $error("pixel_y expected %0d got %0d", want.py, got_y);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_pixel expected %0b got %0b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus: reset, directed table, then three phases of random lines with different idle rates
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_line(directed_rows[i]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 31;
               // sender pause until the rasterizer has fully drained
               drain_pixels();
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < LINES_PER_PH; n++) begin
            // long receiver hold while lines keep being offered, so the input stalls
            if (phase == 0 && n == 10)
               hold_request <= ~hold_request;
            send_line(random_line());
         end
      end

      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
